### rtl/tlex_pkg.sv
// Package for the token lexer: token kinds, error codes, scan modes,
// character codes, keyword table and the character class helpers.
// Depends on nothing; used by rtl/token_lexer.sv.
`default_nettype none

package tlex_pkg;

    localparam int DEF_OFFSET_BITS = 32;
    localparam int DEF_LENGTH_BITS = 16;
    localparam int KIND_W          = 5;
    localparam int ERR_W           = 3;
    localparam int TUSER_W         = KIND_W + 1;
    localparam int PREFIX_BITS     = 48;
    localparam int KW_COUNT        = 8;
    localparam int NUM_FLAGS       = 3;

    // Bit positions inside the number flags.
    localparam int FLAG_HAS_DOT    = 0;
    localparam int FLAG_LEAD_DOT   = 1;
    localparam int FLAG_LEAD_ZERO  = 2;

    typedef enum logic [KIND_W-1:0] {
        K_INT     = 5'd0,
        K_DOUBLE  = 5'd1,
        K_SCANF   = 5'd2,
        K_PRINTF  = 5'd3,
        K_IF      = 5'd4,
        K_THEN    = 5'd5,
        K_WHILE   = 5'd6,
        K_DO      = 5'd7,
        K_IDENT   = 5'd8,
        K_INTEGER = 5'd9,
        K_DECIMAL = 5'd10,
        K_REL     = 5'd11,
        K_LOGIC   = 5'd12,
        K_ASSIGN  = 5'd13,
        K_PLUS    = 5'd14,
        K_MINUS   = 5'd15,
        K_TIMES   = 5'd16,
        K_DIVIDE  = 5'd17,
        K_COMMA   = 5'd18,
        K_BRACKET = 5'd19,
        K_SEMI    = 5'd20,
        K_ERROR   = 5'd21,
        K_END     = 5'd22
    } kind_t;

    typedef enum logic [ERR_W-1:0] {
        E_NONE        = 3'd0,
        E_UNRECOG     = 3'd1,
        E_EXTRA_POINT = 3'd2,
        E_EDGE_POINT  = 3'd3,
        E_LEAD_ZERO   = 3'd4
    } err_t;

    typedef enum logic [3:0] {
        M_IDLE,
        M_SLASH,
        M_LINE,
        M_BLOCK,
        M_IDENT,
        M_NUM,
        M_DOT,
        M_OP,
        M_ERR
    } mode_t;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Keywords packed first byte highest, in kind order.
    localparam logic [PREFIX_BITS-1:0] KW_PREFIX [KW_COUNT] = '{
        48'h0000_0069_6E74,
        48'h646F_7562_6C65,
        48'h0073_6361_6E66,
        48'h7072_696E_7466,
        48'h0000_0000_6966,
        48'h0000_7468_656E,
        48'h0077_6869_6C65,
        48'h0000_0000_646F
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd6, 3'd5, 3'd6, 3'd2, 3'd4, 3'd5, 3'd2
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // len3 is the identifier length, or 7 for anything longer than six.
    function automatic kind_t kw_kind(input logic [PREFIX_BITS-1:0] prefix,
                                      input logic [2:0] len3);
        kind_t kind;
        kind = K_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if ((len3 == KW_LEN[k]) && (prefix == KW_PREFIX[k])) begin
                kind = kind_t'(KIND_W'(k));
            end
        end
        return kind;
    endfunction

    function automatic kind_t single_op_kind(input logic [7:0] p);
        kind_t kind;
        if (p == CH_EQ) begin
            kind = K_ASSIGN;
        end else if (p == CH_BANG) begin
            kind = K_LOGIC;
        end else begin
            kind = K_REL;
        end
        return kind;
    endfunction

endpackage

`default_nettype wire

### rtl/token_lexer.sv
`default_nettype none
// Streaming lexer top level: input register, one-pass scan logic and a
// three-slot result register. Depends on rtl/tlex_pkg.sv.
//
// Usage: source bytes arrive on the s_ channel, one per request, with
// s_tlast on the final byte of a stream. Token events leave on the m_
// channel: kind and stream-done flag in m_tuser, error code, start offset
// and length in m_tdata, and m_tlast on the last event caused by one byte.
// A stream always closes with an end event, or with an error event after
// which the rest of the stream up to s_tlast is dropped silently.
// Path: a taken byte waits in the input register and is scanned from
// there; its events are registered in the result slots that drive m_tdata.
// Throughput: one byte per cycle while the result slots have room. A byte
// with events holds the slots until they drain, and a following byte with
// events waits for the last of them to leave; bytes that yield none keep
// flowing. The limit is the single-event output port draining the slots.
// Reset clears the scan state, the byte counter and all pending events.
// When the receiver stalls, events wait in the result slots and s_tready
// drops as soon as the input register holds a byte that needs a slot.

module token_lexer #(
    parameter int  OFFSET_BITS = tlex_pkg::DEF_OFFSET_BITS,
    parameter int  LENGTH_BITS = tlex_pkg::DEF_LENGTH_BITS,
    localparam int TDATA_W     = ((tlex_pkg::ERR_W + OFFSET_BITS + LENGTH_BITS + 7) / 8) * 8
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,   // [7:0] data_byte
    input  wire logic                         s_tlast,   // end_of_input
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // error_code, token_start, token_length, then zero fill
    output logic [TDATA_W-1:0]                m_tdata,
    output logic [tlex_pkg::TUSER_W-1:0]      m_tuser,   // token_kind, stream_done
    output logic                              m_tlast    // run_last
);
    import tlex_pkg::*;

    typedef struct packed {
        kind_t                  kind;
        err_t                   err;
        logic [OFFSET_BITS-1:0] start;
        logic [LENGTH_BITS-1:0] len;
        logic                   done;
    } res_t;

    function automatic res_t mk_res(input kind_t k, input err_t e,
                                    input logic [OFFSET_BITS-1:0] s,
                                    input logic [LENGTH_BITS-1:0] l, input logic d);
        res_t r;
        r.kind  = k;
        r.err   = e;
        r.start = s;
        r.len   = l;
        r.done  = d;
        return r;
    endfunction

    // Closing a number: edge point wins over leading zero.
    function automatic res_t num_result(input logic [NUM_FLAGS-1:0] fl, input logic [7:0] pc,
                                        input logic [OFFSET_BITS-1:0] st,
                                        input logic [LENGTH_BITS-1:0] ln);
        res_t r;
        r = mk_res(K_INTEGER, E_NONE, st, ln, 1'b0);
        if ((pc == CH_DOT) || fl[FLAG_LEAD_DOT]) begin
            r.kind = K_ERROR;
            r.err  = E_EDGE_POINT;
            r.done = 1'b1;
        end else if (fl[FLAG_LEAD_ZERO]) begin
            r.kind = K_ERROR;
            r.err  = E_LEAD_ZERO;
            r.done = 1'b1;
        end else if (fl[FLAG_HAS_DOT]) begin
            r.kind = K_DECIMAL;
        end
        return r;
    endfunction

    function automatic res_t ident_result(input logic [PREFIX_BITS-1:0] px,
                                          input logic [OFFSET_BITS-1:0] st,
                                          input logic [LENGTH_BITS-1:0] ln);
        logic [2:0] len3;
        len3 = (ln <= LENGTH_BITS'(6)) ? ln[2:0] : 3'd7;
        return mk_res(kw_kind(px, len3), E_NONE, st, ln, 1'b0);
    endfunction

    // Input register
    logic                   in_valid_reg;
    logic [7:0]             byte_reg;
    logic                   last_reg;

    // Scan state
    mode_t                  mode_reg, mode_next;
    logic [7:0]             pend_reg, pend_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [PREFIX_BITS-1:0] prefix_reg, prefix_next;
    logic [NUM_FLAGS-1:0]   flags_reg, flags_next;
    logic                   star_reg, star_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;

    // Result slots; slot 0 drives the output port.
    res_t                   slot_reg [3];
    logic [1:0]             cnt_reg;

    res_t                   res_v [3];
    logic [1:0]             n_res;
    logic                   reproc;
    logic                   ev;
    res_t                   er;
    logic                   slots_free;
    logic                   step_go;
    logic                   load_slots;

    always_comb begin
        mode_next   = mode_reg;
        pend_next   = pend_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        prefix_next = prefix_reg;
        flags_next  = flags_reg;
        star_next   = star_reg;
        pos_next    = pos_reg;
        res_v[0]    = '0;
        res_v[1]    = '0;
        res_v[2]    = '0;
        n_res       = 2'd0;
        reproc      = 1'b0;
        ev          = 1'b0;
        er          = '0;

        if (mode_reg == M_ERR) begin
            if (last_reg) begin
                mode_next   = M_IDLE;
                pend_next   = '0;
                start_next  = '0;
                len_next    = '0;
                prefix_next = '0;
                flags_next  = '0;
                star_next   = 1'b0;
                pos_next    = '0;
            end
        end else begin
            pos_next = pos_reg + OFFSET_BITS'(1);

            // Continue the token in progress with this byte.
            unique case (mode_reg)
                M_IDLE: begin
                    reproc = 1'b1;
                end
                M_SLASH: begin
                    if (byte_reg == CH_SLASH) begin
                        mode_next = M_LINE;
                    end else if (byte_reg == CH_STAR) begin
                        mode_next = M_BLOCK;
                        star_next = 1'b0;
                    end else begin
                        ev        = 1'b1;
                        er        = mk_res(K_DIVIDE, E_NONE, start_next, LENGTH_BITS'(1), 1'b0);
                        mode_next = M_IDLE;
                        reproc    = 1'b1;
                    end
                end
                M_LINE: begin
                    if (byte_reg == CH_NL) begin
                        mode_next = M_IDLE;
                    end
                end
                M_BLOCK: begin
                    if (star_reg && (byte_reg == CH_SLASH)) begin
                        mode_next = M_IDLE;
                        star_next = 1'b0;
                    end else begin
                        star_next = (byte_reg == CH_STAR);
                    end
                end
                M_IDENT: begin
                    if (is_alpha(byte_reg) || is_digit(byte_reg)) begin
                        if (len_next < LENGTH_BITS'(6)) begin
                            prefix_next = {prefix_next[PREFIX_BITS-9:0], byte_reg};
                        end
                        if (len_next != '1) begin
                            len_next = len_next + LENGTH_BITS'(1);
                        end
                    end else begin
                        ev        = 1'b1;
                        er        = ident_result(prefix_next, start_next, len_next);
                        mode_next = M_IDLE;
                        reproc    = 1'b1;
                    end
                end
                M_NUM: begin
                    if (is_digit(byte_reg)) begin
                        if (!flags_next[FLAG_HAS_DOT] && (len_next == LENGTH_BITS'(1))
                                && (pend_next == CH_ZERO)) begin
                            flags_next[FLAG_LEAD_ZERO] = 1'b1;
                        end
                        if (len_next != '1) begin
                            len_next = len_next + LENGTH_BITS'(1);
                        end
                        pend_next = byte_reg;
                    end else if (byte_reg == CH_DOT) begin
                        if (len_next != '1) begin
                            len_next = len_next + LENGTH_BITS'(1);
                        end
                        if (flags_next[FLAG_HAS_DOT]) begin
                            ev        = 1'b1;
                            er        = mk_res(K_ERROR, E_EXTRA_POINT, start_next, len_next, 1'b1);
                            mode_next = M_ERR;
                        end else begin
                            flags_next[FLAG_HAS_DOT] = 1'b1;
                            pend_next                = byte_reg;
                        end
                    end else begin
                        ev        = 1'b1;
                        er        = num_result(flags_next, pend_next, start_next, len_next);
                        mode_next = (er.kind == K_ERROR) ? M_ERR : M_IDLE;
                        reproc    = (mode_next == M_IDLE);
                    end
                end
                M_DOT: begin
                    if (is_digit(byte_reg)) begin
                        mode_next  = M_NUM;
                        flags_next = '0;
                        flags_next[FLAG_HAS_DOT]  = 1'b1;
                        flags_next[FLAG_LEAD_DOT] = 1'b1;
                        len_next   = LENGTH_BITS'(2);
                        pend_next  = byte_reg;
                    end else begin
                        ev        = 1'b1;
                        er        = mk_res(K_ERROR, E_UNRECOG, start_next, LENGTH_BITS'(1), 1'b1);
                        mode_next = M_ERR;
                    end
                end
                M_OP: begin
                    if (((pend_next == CH_EQ) || (pend_next == CH_GT) || (pend_next == CH_LT)
                            || (pend_next == CH_BANG)) && (byte_reg == CH_EQ)) begin
                        ev        = 1'b1;
                        er        = mk_res(K_REL, E_NONE, start_next, LENGTH_BITS'(2), 1'b0);
                        mode_next = M_IDLE;
                    end else if (((pend_next == CH_AMP) || (pend_next == CH_BAR))
                            && (byte_reg == pend_next)) begin
                        ev        = 1'b1;
                        er        = mk_res(K_LOGIC, E_NONE, start_next, LENGTH_BITS'(2), 1'b0);
                        mode_next = M_IDLE;
                    end else if ((pend_next == CH_AMP) || (pend_next == CH_BAR)) begin
                        ev        = 1'b1;
                        er        = mk_res(K_ERROR, E_UNRECOG, start_next, LENGTH_BITS'(1), 1'b1);
                        mode_next = M_ERR;
                    end else begin
                        ev        = 1'b1;
                        er        = mk_res(single_op_kind(pend_next), E_NONE, start_next,
                                           LENGTH_BITS'(1), 1'b0);
                        mode_next = M_IDLE;
                        reproc    = 1'b1;
                    end
                end
                default: begin
                    mode_next = M_IDLE;
                    reproc    = 1'b1;
                end
            endcase
            if (ev && (n_res != 2'd3)) begin
                res_v[n_res] = er;
                n_res        = n_res + 2'd1;
            end
            ev = 1'b0;

            // A byte that ended the previous token may open the next one.
            if (reproc && (mode_next == M_IDLE)) begin
                start_next = pos_reg;
                if (is_space(byte_reg)) begin
                    mode_next = M_IDLE;
                end else if (is_alpha(byte_reg)) begin
                    mode_next   = M_IDENT;
                    len_next    = LENGTH_BITS'(1);
                    prefix_next = PREFIX_BITS'(byte_reg);
                end else if (is_digit(byte_reg)) begin
                    mode_next  = M_NUM;
                    len_next   = LENGTH_BITS'(1);
                    flags_next = '0;
                    pend_next  = byte_reg;
                end else begin
                    case (byte_reg) inside
                        CH_SLASH: begin
                            mode_next = M_SLASH;
                        end
                        CH_DOT: begin
                            mode_next = M_DOT;
                        end
                        CH_EQ, CH_GT, CH_LT, CH_BANG, CH_AMP, CH_BAR: begin
                            mode_next = M_OP;
                            pend_next = byte_reg;
                        end
                        CH_PLUS: begin
                            ev = 1'b1;
                            er = mk_res(K_PLUS, E_NONE, pos_reg, LENGTH_BITS'(1), 1'b0);
                        end
                        CH_MINUS: begin
                            ev = 1'b1;
                            er = mk_res(K_MINUS, E_NONE, pos_reg, LENGTH_BITS'(1), 1'b0);
                        end
                        CH_STAR: begin
                            ev = 1'b1;
                            er = mk_res(K_TIMES, E_NONE, pos_reg, LENGTH_BITS'(1), 1'b0);
                        end
                        CH_COMMA: begin
                            ev = 1'b1;
                            er = mk_res(K_COMMA, E_NONE, pos_reg, LENGTH_BITS'(1), 1'b0);
                        end
                        CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE: begin
                            ev = 1'b1;
                            er = mk_res(K_BRACKET, E_NONE, pos_reg, LENGTH_BITS'(1), 1'b0);
                        end
                        CH_SEMI: begin
                            ev = 1'b1;
                            er = mk_res(K_SEMI, E_NONE, pos_reg, LENGTH_BITS'(1), 1'b0);
                        end
                        default: begin
                            ev        = 1'b1;
                            er        = mk_res(K_ERROR, E_UNRECOG, pos_reg, LENGTH_BITS'(1), 1'b1);
                            mode_next = M_ERR;
                        end
                    endcase
                end
            end
            if (ev && (n_res != 2'd3)) begin
                res_v[n_res] = er;
                n_res        = n_res + 2'd1;
            end
            ev = 1'b0;

            if (last_reg) begin
                // Flush whatever token is still open; open comments vanish.
                unique case (mode_next)
                    M_SLASH: begin
                        ev = 1'b1;
                        er = mk_res(K_DIVIDE, E_NONE, start_next, LENGTH_BITS'(1), 1'b0);
                    end
                    M_IDENT: begin
                        ev        = 1'b1;
                        er        = ident_result(prefix_next, start_next, len_next);
                        mode_next = M_IDLE;
                    end
                    M_NUM: begin
                        ev        = 1'b1;
                        er        = num_result(flags_next, pend_next, start_next, len_next);
                        mode_next = (er.kind == K_ERROR) ? M_ERR : M_IDLE;
                    end
                    M_DOT: begin
                        ev        = 1'b1;
                        er        = mk_res(K_ERROR, E_UNRECOG, start_next, LENGTH_BITS'(1), 1'b1);
                        mode_next = M_ERR;
                    end
                    M_OP: begin
                        ev = 1'b1;
                        if ((pend_next == CH_AMP) || (pend_next == CH_BAR)) begin
                            er        = mk_res(K_ERROR, E_UNRECOG, start_next,
                                               LENGTH_BITS'(1), 1'b1);
                            mode_next = M_ERR;
                        end else begin
                            er = mk_res(single_op_kind(pend_next), E_NONE, start_next,
                                        LENGTH_BITS'(1), 1'b0);
                        end
                    end
                    default: begin
                        ev = 1'b0;
                    end
                endcase
                if (ev && (n_res != 2'd3)) begin
                    res_v[n_res] = er;
                    n_res        = n_res + 2'd1;
                end
                ev = 1'b0;

                if (mode_next != M_ERR) begin
                    ev = 1'b1;
                    er = mk_res(K_END, E_NONE, pos_next, '0, 1'b1);
                end
                if (ev && (n_res != 2'd3)) begin
                    res_v[n_res] = er;
                    n_res        = n_res + 2'd1;
                end

                mode_next   = M_IDLE;
                pend_next   = '0;
                start_next  = '0;
                len_next    = '0;
                prefix_next = '0;
                flags_next  = '0;
                star_next   = 1'b0;
                pos_next    = '0;
            end
        end
    end

    // The slots take a new set of events once the last waiting one leaves.
    assign slots_free = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign step_go    = in_valid_reg && ((n_res == 2'd0) || slots_free);
    assign load_slots = step_go && (n_res != 2'd0);
    assign s_tready   = !in_valid_reg || step_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= M_IDLE;
            pend_reg   <= '0;
            start_reg  <= '0;
            len_reg    <= '0;
            prefix_reg <= '0;
            flags_reg  <= '0;
            star_reg   <= 1'b0;
            pos_reg    <= '0;
        end else if (step_go) begin
            mode_reg   <= mode_next;
            pend_reg   <= pend_next;
            start_reg  <= start_next;
            len_reg    <= len_next;
            prefix_reg <= prefix_next;
            flags_reg  <= flags_next;
            star_reg   <= star_next;
            pos_reg    <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (load_slots) begin
            cnt_reg <= n_res;
        end else if (m_tvalid && m_tready) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
        if (load_slots) begin
            slot_reg[0] <= res_v[0];
            slot_reg[1] <= res_v[1];
            slot_reg[2] <= res_v[2];
        end else if (m_tvalid && m_tready) begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tlast  = (cnt_reg == 2'd1);
    assign m_tuser  = {slot_reg[0].done, slot_reg[0].kind};
    assign m_tdata  = TDATA_W'({slot_reg[0].len, slot_reg[0].start, slot_reg[0].err});

    // An event that closes a stream is always the last one of its byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && slot_reg[0].done |-> m_tlast)
        else $error("stream close event is not the last event of its byte");

    // Error code is set exactly on error events.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((slot_reg[0].kind == K_ERROR) == (slot_reg[0].err != E_NONE)))
        else $error("error code does not match event kind");

    // Bytes after an error produce nothing.
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_go && (mode_reg == M_ERR) |-> (n_res == 2'd0))
        else $error("event produced while dropping a failed stream");

    // End of input always leaves the scanner fresh for the next stream.
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_go && last_reg |=> (mode_reg == M_IDLE) && (pos_reg == '0))
        else $error("scanner not reset after end of input");

endmodule

`default_nettype wire
